>>> src/srs_pkg.sv
// Shared types, constants and fixed-point helpers for the systematic resampler.
// Used by srs_core, systematic_resampler_top and srs_check.
package srs_pkg;

   // Store geometry and fixed-point format
   localparam int MAX_POINTS = 1024;
   localparam int FRAC_BITS  = 24;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int FIX_W      = FRAC_BITS + 1;
   localparam int SUM_W      = 32;
   localparam int DRAW_W     = 11;
   localparam int NUM_W      = 10;

   localparam logic [FIX_W-1:0] ONE_FIX = FIX_W'(1) << FRAC_BITS;

   // Request kinds carried on req_tuser
   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_DRAW  = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_LOCAL_COUNT  = 2'd0;
   localparam logic [1:0] REG_STRIDE       = 2'd1;
   localparam logic [1:0] REG_START_OFFSET = 2'd2;

   typedef struct packed {
      logic [DRAW_W-1:0] local_count;
      logic [FIX_W-1:0]  stride;
      logic [FIX_W-1:0]  start_offset;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0] source_index;
      logic [NUM_W-1:0] draw_number;
      logic             last;
      logic             overrun;
   } result_type;

   // Limit a fixed-point value to 1.0
   function automatic logic [FIX_W-1:0] clamp_one(input logic [FIX_W-1:0] v);
      return (v > ONE_FIX) ? ONE_FIX : v;
   endfunction

   // Add with saturation at the top of the sum range
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

endpackage

>>> src/systematic_resampler_top.sv
// Systematic resampler top: stream ports, APB-style register port, result register.
// Depends on srs_pkg and srs_core.
// Clear and load items complete as they are accepted; a draw walks the store from the
// walk pointer (one store read per cycle), then emits its result and returns to idle.
// A new item is taken while a finished result waits in the output register.
// Synchronous reset clears the pass state and loads register defaults
// (local_count 1, stride 1.0, start_offset 0); the store keeps no reset value.
module systematic_resampler_top
   import srs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [24:0] weight, [31:25] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // Result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] source_index, [19:10] draw_number, [23:20] zero
   output logic        rsp_tlast,   // last
   output logic [0:0]  rsp_tuser,   // [0] overrun
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type     cfg_ff, cfg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   logic        slot_free;
   logic        res_valid;
   result_type  res;
   logic        csr_write;
   logic [1:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_LOCAL_COUNT:  cfg_in.local_count  = csr_pwdata[DRAW_W-1:0];
            REG_STRIDE:       cfg_in.stride       = csr_pwdata[FIX_W-1:0];
            REG_START_OFFSET: cfg_in.start_offset = csr_pwdata[FIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (csr_index)
         REG_LOCAL_COUNT:  csr_prdata = 32'(cfg_ff.local_count);
         REG_STRIDE:       csr_prdata = 32'(cfg_ff.stride);
         REG_START_OFFSET: csr_prdata = 32'(cfg_ff.start_offset);
         default:          csr_prdata = '0;
      endcase
   end

   srs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_kind   (req_tuser),
      .in_weight (req_tdata[FIX_W-1:0]),
      .cfg       (cfg_ff),
      .slot_free (slot_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register: hold the item until taken
   assign slot_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cfg_ff.local_count  <= DRAW_W'(1);
         cfg_ff.stride       <= ONE_FIX;
         cfg_ff.start_offset <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_ff.draw_number, rsp_ff.source_index};
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tuser  = rsp_ff.overrun;

endmodule

>>> src/srs_core.sv
// Resampler engine: cumulative-sum store, walk pointer and draw sequencer.
// Depends on srs_pkg for types, widths and the saturating helpers.
module srs_core
   import srs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [1:0]       in_kind,
   input  logic [FIX_W-1:0] in_weight,
   input  cfg_type          cfg,
   input  logic             slot_free,
   output logic             res_valid,
   output result_type       res
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [SUM_W-1:0]  running_sum_ff, running_sum_in;
   logic [CNT_W-1:0]  loaded_count_ff, loaded_count_in;
   logic [IDX_W-1:0]  walk_ptr_ff, walk_ptr_in;
   logic [SUM_W-1:0]  threshold_ff, threshold_in;
   logic [DRAW_W-1:0] draws_done_ff, draws_done_in;
   logic              walk_over_ff, walk_over_in;

   // Cumulative-sum store, one write and one registered read port
   logic [SUM_W-1:0]  store [MAX_POINTS];
   logic [SUM_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [SUM_W-1:0]  wr_data;

   logic              accept;
   logic [IDX_W-1:0]  top_idx;
   logic [IDX_W-1:0]  ptr_clamped;
   logic              thr_above;
   logic              more_room;

   assign accept    = in_valid && in_ready;
   assign in_ready  = (state_ff == ST_IDLE);
   assign top_idx   = IDX_W'(loaded_count_ff - CNT_W'(1));
   assign ptr_clamped = (walk_ptr_ff > top_idx) ? top_idx : walk_ptr_ff;
   assign thr_above = threshold_ff > rd_data_ff;
   assign more_room = loaded_count_ff < CNT_W'(MAX_POINTS);
   assign wr_data   = sat_add(running_sum_ff, SUM_W'(clamp_one(in_weight)));
   assign wr_en     = accept && (in_kind == REQ_LOAD) && more_room;

   // Read the clamped pointer on a draw, the next entry while walking
   always_comb begin
      if (state_ff == ST_WALK) begin
         rd_addr = walk_ptr_ff + IDX_W'(1);
      end else begin
         rd_addr = ptr_clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[loaded_count_ff[IDX_W-1:0]] <= wr_data;
      end
      rd_data_ff <= store[rd_addr];
   end

   // Sequencer and pass state
   always_comb begin
      state_in        = state_ff;
      running_sum_in  = running_sum_ff;
      loaded_count_in = loaded_count_ff;
      walk_ptr_in     = walk_ptr_ff;
      threshold_in    = threshold_ff;
      draws_done_in   = draws_done_ff;
      walk_over_in    = walk_over_ff;
      res_valid       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (in_kind)
                  REQ_CLEAR: begin
                     running_sum_in  = '0;
                     loaded_count_in = '0;
                     walk_ptr_in     = '0;
                     threshold_in    = '0;
                     draws_done_in   = '0;
                  end
                  REQ_LOAD: begin
                     if (more_room) begin
                        running_sum_in  = wr_data;
                        loaded_count_in = loaded_count_ff + CNT_W'(1);
                     end
                  end
                  REQ_DRAW: begin
                     if (draws_done_ff == '0) begin
                        threshold_in = SUM_W'(clamp_one(cfg.start_offset));
                     end else begin
                        threshold_in = sat_add(threshold_ff,
                                               SUM_W'(clamp_one(cfg.stride)));
                     end
                     if (loaded_count_ff == '0) begin
                        walk_over_in = 1'b1;
                        walk_ptr_in  = '0;
                        state_in     = ST_EMIT;
                     end else begin
                        walk_ptr_in = ptr_clamped;
                        state_in    = ST_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // Advance one entry per cycle until the threshold is covered or the last loaded entry is reached
            if ((walk_ptr_ff < top_idx) && thr_above) begin
               walk_ptr_in = walk_ptr_ff + IDX_W'(1);
            end else begin
               walk_over_in = thr_above;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               res_valid    = 1'b1;
               walk_over_in = 1'b0;
               if (draws_done_ff != {DRAW_W{1'b1}}) begin
                  draws_done_in = draws_done_ff + DRAW_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result fields, valid while res_valid is high
   always_comb begin
      res.source_index = (loaded_count_ff == '0) ? '0 : walk_ptr_ff;
      res.draw_number  = draws_done_ff[NUM_W-1:0];
      res.last         = (cfg.local_count != '0) &&
                         (draws_done_ff == cfg.local_count - DRAW_W'(1));
      res.overrun      = walk_over_ff || (draws_done_ff >= cfg.local_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         running_sum_ff  <= '0;
         loaded_count_ff <= '0;
         walk_ptr_ff     <= '0;
         threshold_ff    <= '0;
         draws_done_ff   <= '0;
         walk_over_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         running_sum_ff  <= running_sum_in;
         loaded_count_ff <= loaded_count_in;
         walk_ptr_ff     <= walk_ptr_in;
         threshold_ff    <= threshold_in;
         draws_done_ff   <= draws_done_in;
         walk_over_ff    <= walk_over_in;
      end
   end

endmodule

>>> src/srs_check.sv
// Port-level checks for systematic_resampler_top, attached by bind.
// Depends on srs_pkg for the request kind codes.
module srs_check
   import srs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Drop any pending result on reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A draw occupies the engine: no new item right after it
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_DRAW) |=> !req_tready)
      else $error("item taken while a draw is in progress");

   // An accepted item means the engine was idle, so no result appears next
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared without a draw walk");

endmodule

bind systematic_resampler_top srs_check u_srs_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
